// ===== hdl/gnd_pkg.sv =====
`default_nettype none
package gnd_pkg;
    localparam int unsigned NUM_DIMS = 4;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam logic [2:0] REG_DATA_RANK = 3'd0;
    localparam logic [2:0] REG_BATCH_DIMS = 3'd1;
    localparam logic [2:0] REG_TUPLE_LEN = 3'd2;
    localparam logic [2:0] REG_DIM_SIZE_0 = 3'd3;
    localparam logic [2:0] REG_DIM_SIZE_1 = 3'd4;
    localparam logic [2:0] REG_DIM_SIZE_2 = 3'd5;
    localparam logic [2:0] REG_DIM_SIZE_3 = 3'd6;
    localparam logic [2:0] REG_TUPLES_PER_BATCH = 3'd7;
endpackage
`default_nettype wire

// ===== hdl/gnd_front.sv =====
`default_nettype none
// front: products of index and stride, error flag, per-word counters
module gnd_front #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [1:0]             i_b,
    input  wire logic [2:0]             i_t,
    input  wire logic [63:0]            i_dims,
    input  wire logic [OFFSET_BITS-1:0] i_s0,
    input  wire logic [OFFSET_BITS-1:0] i_s1,
    input  wire logic [OFFSET_BITS-1:0] i_s2,
    input  wire logic [OFFSET_BITS-1:0] i_s3,
    input  wire logic [15:0]            i_tpb,
    input  wire logic [15:0]            i_idx0,
    input  wire logic [15:0]            i_idx1,
    input  wire logic [15:0]            i_idx2,
    input  wire logic [15:0]            i_idx3,
    output logic                        o_valid,
    output logic [OFFSET_BITS-1:0]      o_sum,
    output logic [OFFSET_BITS-1:0]      o_base,
    output logic [OFFSET_BITS-1:0]      o_dst,
    output logic [OFFSET_BITS-1:0]      o_slice,
    output logic                        o_err
);
    logic [OFFSET_BITS-1:0] w_str [4];
    logic [15:0]            w_ix [4];
    logic [OFFSET_BITS-1:0] r_p [4];
    logic                   r_err, r_v;
    logic [OFFSET_BITS-1:0] r_base, r_dst, r_slice, r_bb, r_acc;
    logic [15:0]            r_cnt;
    logic [OFFSET_BITS-1:0] w_slice, w_bstep;
    logic                   w_err;
    logic [15:0]            w_cnt1, w_tpb;
    logic [1:0]             w_last;

    assign w_str[0] = i_s0;
    assign w_str[1] = i_s1;
    assign w_str[2] = i_s2;
    assign w_str[3] = i_s3;
    assign w_ix[0] = i_idx0;
    assign w_ix[1] = i_idx1;
    assign w_ix[2] = i_idx2;
    assign w_ix[3] = i_idx3;

    always_comb begin
        logic [2:0] d;
        w_err = 1'b0;
        for (int j = 0; j < 4; j++) begin
            d = 3'(i_b) + 3'(j);
            if (3'(j) < i_t && i_dims[d[1:0]*16 +: 16] <= w_ix[j]) begin
                w_err = 1'b1;
            end
        end
        w_last = 2'(3'(i_b) + i_t - 3'd1);
        w_slice = w_str[w_last];
        w_bstep = (i_b == 2'd0) ? '0 : w_str[i_b - 2'd1];
        w_tpb = (i_tpb == 16'd0) ? 16'd1 : i_tpb;
        w_cnt1 = r_cnt + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            r_acc <= '0;
            r_bb <= '0;
            r_cnt <= '0;
        end else begin
            r_v <= i_take;
            if (i_take) begin
                r_acc <= r_acc + w_slice;
                if (w_cnt1 >= w_tpb || w_cnt1 == 16'd0) begin
                    r_cnt <= '0;
                    r_bb <= r_bb + w_bstep;
                end else begin
                    r_cnt <= w_cnt1;
                end
            end
        end
        if (i_take) begin
            for (int j = 0; j < 4; j++) begin
                logic [2:0] dd;
                dd = 3'(i_b) + 3'(j);
                r_p[j] <= (3'(j) < i_t) ? OFFSET_BITS'(w_ix[j] * w_str[dd[1:0]]) : '0;
            end
            r_err <= w_err;
            r_base <= r_bb;
            r_dst <= r_acc;
            r_slice <= w_slice;
        end
    end

    assign o_valid = r_v;
    assign o_sum = r_p[0] + r_p[1] + r_p[2] + r_p[3];
    assign o_base = r_base;
    assign o_dst = r_dst;
    assign o_slice = r_slice;
    assign o_err = r_err;
endmodule
`default_nettype wire

// ===== hdl/gnd_queue.sv =====
`default_nettype none
// result queue, four deep, registered words
module gnd_queue #(
    parameter int unsigned W = 97
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [2:0]        o_count,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [4];
    logic [1:0]   r_wp, r_rp;
    logic [2:0]   r_cnt;
    logic         w_pop;

    assign w_pop = i_pop && r_cnt != 3'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(w_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_empty = r_cnt == 3'd0;
    assign o_count = r_cnt;
    assign o_data = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_cnt == 3'd4 && !w_pop)) else $error("queue overflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("count range");
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> r_wp == r_rp) else $error("pointer mismatch");
endmodule
`default_nettype wire

// ===== hdl/gather_nd_address_generator.sv =====
`default_nettype none
// path: a pushed word is registered in the front stage, then written to the result queue, from which it can be popped
// throughput: one word per cycle; full rises when the result queue, with a word
//   in the front stage, holds three words, and after a register write while
//   the stride chain settles
// reset: synchronous active low; registers return to rank 1, one-element shape,
//   counters and offsets cleared
module gather_nd_address_generator #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_idx0,
    input  wire logic [15:0] i_idx1,
    input  wire logic [15:0] i_idx2,
    input  wire logic [15:0] i_idx3,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_src_offset,
    output logic [31:0]      o_dst_offset,
    output logic [31:0]      o_slice_length,
    output logic             o_index_error,
    input  wire logic        i_cfg_we,
    input  wire logic [gnd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [gnd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    // configuration registers
    logic [2:0]  r_rank, r_tlen;
    logic [1:0]  r_bdims;
    logic [15:0] r_dim [4];
    logic [15:0] r_tpb;
    // strides, one link of the chain per cycle, settling link by link after a write
    logic [OFFSET_BITS-1:0] r_str [4];
    logic [OFFSET_BITS-1:0] n_str [4];
    // cycles left until the strides are settled
    logic [1:0] r_settle;
    logic [2:0] w_r, w_t, w_lim;
    logic [1:0] w_b;
    logic       w_take;
    logic       f_v, f_err;
    logic [OFFSET_BITS-1:0] f_sum, f_base, f_dst, f_slice, w_src;
    logic [2:0] q_cnt;
    logic [96:0] q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= 3'd1;
            r_bdims <= 2'd0;
            r_tlen <= 3'd1;
            r_tpb <= 16'd1;
            r_settle <= 2'd0;
            for (int i = 0; i < 4; i++) r_dim[i] <= 16'd1;
            for (int i = 0; i < 4; i++) r_str[i] <= OFFSET_BITS'(1);
        end else begin
            r_str <= n_str;
            if (i_cfg_we) begin
                r_settle <= 2'd3;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gnd_pkg::REG_DATA_RANK:        r_rank <= i_cfg_data[2:0];
                    gnd_pkg::REG_BATCH_DIMS:       r_bdims <= i_cfg_data[1:0];
                    gnd_pkg::REG_TUPLE_LEN:        r_tlen <= i_cfg_data[2:0];
                    gnd_pkg::REG_DIM_SIZE_0:       r_dim[0] <= i_cfg_data;
                    gnd_pkg::REG_DIM_SIZE_1:       r_dim[1] <= i_cfg_data;
                    gnd_pkg::REG_DIM_SIZE_2:       r_dim[2] <= i_cfg_data;
                    gnd_pkg::REG_DIM_SIZE_3:       r_dim[3] <= i_cfg_data;
                    gnd_pkg::REG_TUPLES_PER_BATCH: r_tpb <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // effective rank, batch dims and tuple length
    always_comb begin
        w_r = (r_rank == 3'd0) ? 3'd1 : (r_rank > 3'd4) ? 3'd4 : r_rank;
        w_b = (3'(r_bdims) > w_r - 3'd1) ? 2'(w_r - 3'd1) : r_bdims;
        w_lim = w_r - 3'(w_b);
        w_t = (r_tlen == 3'd0) ? 3'd1 : (r_tlen > 3'd4) ? 3'd4 : r_tlen;
        if (w_t > w_lim) w_t = w_lim;
        // stride chain: one 16x32 multiply per stride but the innermost, read from registered strides
        for (int i = 0; i < 4; i++) begin
            if (3'(i) + 3'd1 < w_r) begin
                n_str[i] = (i < 3) ? OFFSET_BITS'(r_str[(i+1)%4] * r_dim[(i+1)%4])
                                   : OFFSET_BITS'(1);
            end else begin
                n_str[i] = OFFSET_BITS'(1);
            end
        end
    end

    // stall when queue plus front stage could overflow, or strides still settling
    assign full = ((q_cnt + 3'(f_v)) >= 3'd3) || (r_settle != 2'd0);
    assign w_take = push && !full;

    gnd_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_b(w_b), .i_t(w_t),
        .i_dims({r_dim[3], r_dim[2], r_dim[1], r_dim[0]}),
        .i_s0(r_str[0]), .i_s1(r_str[1]), .i_s2(r_str[2]), .i_s3(r_str[3]),
        .i_tpb(r_tpb),
        .i_idx0(i_idx0), .i_idx1(i_idx1), .i_idx2(i_idx2), .i_idx3(i_idx3),
        .o_valid(f_v), .o_sum(f_sum), .o_base(f_base), .o_dst(f_dst),
        .o_slice(f_slice), .o_err(f_err)
    );

    assign w_src = f_base + f_sum;

    gnd_queue #(.W(97)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_v),
        .i_data({32'(w_src), 32'(f_dst), 32'(f_slice), f_err}),
        .i_pop(pop), .o_empty(empty), .o_count(q_cnt), .o_data(q_out)
    );

    assign o_src_offset = q_out[96:65];
    assign o_dst_offset = q_out[64:33];
    assign o_slice_length = q_out[32:1];
    assign o_index_error = q_out[0];

    a_full_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> q_cnt + 3'(f_v) <= 3'd2) else $error("no room");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> f_v) else $error("front lost word");
    a_stride_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_str[3] == OFFSET_BITS'(1)) else $error("innermost stride");
endmodule
`default_nettype wire
